// ===== rtl/periodic_timer_slot_table_unit_defines.svh =====
// Assertion macros for the timer slot table RTL.
`ifndef PERIODIC_TIMER_SLOT_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_SLOT_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PTST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PTST_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PTST_ASSERT(lbl, prop, msg)
`define PTST_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/ptst_pkg.sv =====
// Package with types, constants and helpers of the timer slot table.
`default_nettype none
package ptst_pkg;
   localparam int SLOT_TOTAL = 8;
   localparam int SLOT_AW = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
   localparam int PER_W = 26;
   localparam logic [PER_W-1:0] US_PER_MS = PER_W'(1000);
   localparam logic [3:0] MAX_TICKS = 4'd8;
   localparam logic [15:0] MIN_IVL_RESET = 16'd16;
   localparam logic [15:0] MAX_IVL_RESET = 16'd1000;

   localparam logic [2:0] MODE_ARM       = 3'd0;
   localparam logic [2:0] MODE_CLR_OWNER = 3'd1;
   localparam logic [2:0] MODE_CANCEL    = 3'd2;
   localparam logic [2:0] MODE_TAKE_DUE  = 3'd3;
   localparam logic [2:0] MODE_CONSUME   = 3'd4;
   localparam logic [2:0] MODE_POST_FAIL = 3'd5;

   localparam logic [7:0] CSR_MIN_IVL = 8'd0;
   localparam logic [7:0] CSR_MAX_IVL = 8'd1;

   typedef struct packed {
      logic [15:0] interval;
      logic        pending;
      logic [63:0] due;
      logic [31:0] owner;
      logic [31:0] gen;
   } slot_entry_type;

   typedef struct packed {
      logic        status;
      logic        tick_valid;
      logic [2:0]  tick_slot;
      logic [31:0] tick_gen;
      logic [31:0] owner;
      logic        last;
   } rsp_type;

   function automatic slot_entry_type kill_entry(slot_entry_type e);
      slot_entry_type k;
      k = '0;
      k.gen = e.gen + 32'd1;
      return k;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/periodic_timer_slot_table_unit.sv =====
// Top level of the periodic timer slot table: sequencer around the slot RAM.
//
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | mode, slot, owner, interval, time, gen, limit
//  rsp     | out       | rsp_valid/stall  | status, tick, slot, gen, owner, last
//  csr     | in        | csr_valid/ready  | index, write data
//
// Arm, consume and post failed read one slot, may update it and answer. Clear
// owner and cancel all sweep the slot RAM, reading and then updating each slot.
// Take due sweeps the slots, runs the serial 64-bit remainder on each due slot.
// Reset clears the per-slot valid bits at once; no clearing pass is needed.
// A stalled result holds the sequencer only when it has a new result to show.
`default_nettype none
`include "periodic_timer_slot_table_unit_defines.svh"
module periodic_timer_slot_table_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_mode,
   input  wire logic [7:0]  req_slot_index,
   input  wire logic [31:0] req_owner_id,
   input  wire logic [15:0] req_interval_ms,
   input  wire logic [63:0] req_time_us,
   input  wire logic [31:0] req_ticket_gen,
   input  wire logic [3:0]  req_tick_limit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_status,
   output logic             rsp_tick_valid,
   output logic [2:0]       rsp_tick_slot,
   output logic [31:0]      rsp_tick_gen,
   output logic [31:0]      rsp_owner_out,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import ptst_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_RD   = 9'b000000010,
      S_EXEC = 9'b000000100,
      S_RSP  = 9'b000001000,
      S_SRD  = 9'b000010000,
      S_SEX  = 9'b000100000,
      S_DIV  = 9'b001000000,
      S_HOLD = 9'b010000000,
      S_FIN  = 9'b100000000
   } state_type;

   localparam int EW = $bits(slot_entry_type);

   state_type        state_ff, state_in;
   logic [15:0]      min_ivl_ff, max_ivl_ff;
   logic [2:0]       mode_ff;
   logic [31:0]      owner_ff;
   logic [15:0]      ivl_ff;
   logic [63:0]      now_ff;
   logic [31:0]      gen_ff;
   logic [3:0]       limit_ff, limit_in;
   logic [SLOT_AW-1:0] idx_ff, idx_in;
   logic [3:0]       count_ff, count_in;
   logic             held_valid_ff, held_valid_in;
   logic [2:0]       held_slot_ff, held_slot_in;
   logic [31:0]      held_gen_ff, held_gen_in;
   slot_entry_type   cur_ff, cur_in;
   logic             resp_status_ff, resp_status_in;
   logic [31:0]      resp_owner_ff, resp_owner_in;
   logic [SLOT_TOTAL-1:0] valid_ff;
   logic             rd_valid_ff;
   rsp_type          out_ff, out_next;
   logic             rsp_valid_ff;

   logic             rd_en, wr_en, load_out, take_req, div_start, div_done, advance;
   logic [SLOT_AW-1:0] wr_addr;
   logic [EW-1:0]    rd_data, wr_data;
   slot_entry_type   entry, new_entry;
   logic             slot_ok, ivl_bad, out_free, last_idx, eligible;
   logic [PER_W-1:0] per_arm, per_cur, div_rem;
   logic [64:0]      arm_sum, due_sum;
   logic [63:0]      base, new_due;
   logic [7:0]       idx_ext;

   assign slot_ok  = {1'b0, req_slot_index} < 9'(SLOT_TOTAL);
   assign ivl_bad  = (req_interval_ms != 16'd0) &&
                     ((req_interval_ms < min_ivl_ff) || (req_interval_ms > max_ivl_ff));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_idx = idx_ff == SLOT_AW'(SLOT_TOTAL - 1);
   assign entry    = rd_valid_ff ? slot_entry_type'(rd_data) : '0;
   assign eligible = (entry.interval != 16'd0) && !entry.pending && (now_ff >= entry.due);
   assign per_arm  = PER_W'(ivl_ff) * US_PER_MS;
   assign per_cur  = PER_W'(cur_ff.interval) * US_PER_MS;
   assign arm_sum  = {1'b0, now_ff} + 65'(per_arm);
   assign base     = now_ff - 64'(div_rem);
   assign due_sum  = {1'b0, base} + 65'(per_cur);
   assign new_due  = due_sum[64] ? '1 : due_sum[63:0];
   assign idx_ext  = 8'(idx_ff);
   assign limit_in = (req_tick_limit > MAX_TICKS) ? MAX_TICKS : req_tick_limit;

   ptst_ram #(.WIDTH(EW), .DEPTH(SLOT_TOTAL)) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   ptst_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (now_ff - entry.due),
      .divisor   (PER_W'(entry.interval) * US_PER_MS),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      held_valid_in  = held_valid_ff;
      held_slot_in   = held_slot_ff;
      held_gen_in    = held_gen_ff;
      cur_in         = cur_ff;
      resp_status_in = resp_status_ff;
      resp_owner_in  = resp_owner_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      new_entry      = entry;
      div_start      = 1'b0;
      load_out       = 1'b0;
      take_req       = 1'b0;
      advance        = 1'b0;
      out_next       = '0;
      out_next.last  = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               take_req       = 1'b1;
               idx_in         = '0;
               count_in       = '0;
               held_valid_in  = 1'b0;
               resp_status_in = 1'b1;
               resp_owner_in  = '0;
               unique case (req_mode)
                  MODE_ARM: begin
                     idx_in   = req_slot_index[SLOT_AW-1:0];
                     state_in = (slot_ok && !ivl_bad) ? S_RD : S_RSP;
                  end
                  MODE_CONSUME, MODE_POST_FAIL: begin
                     idx_in   = req_slot_index[SLOT_AW-1:0];
                     state_in = slot_ok ? S_RD : S_RSP;
                  end
                  MODE_CLR_OWNER, MODE_CANCEL: state_in = S_SRD;
                  MODE_TAKE_DUE: state_in = (limit_in == 4'd0) ? S_RSP : S_SRD;
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (mode_ff)
               MODE_ARM: begin
                  new_entry = kill_entry(entry);
                  if ((ivl_ff != 16'd0) && !arm_sum[64]) begin
                     new_entry.owner    = owner_ff;
                     new_entry.interval = ivl_ff;
                     new_entry.due      = arm_sum[63:0];
                  end
                  wr_en          = 1'b1;
                  resp_status_in = (ivl_ff != 16'd0) && arm_sum[64];
               end
               MODE_CONSUME: begin
                  if (entry.pending && (entry.gen == gen_ff)) begin
                     new_entry.pending = 1'b0;
                     wr_en = 1'b1;
                     if (entry.interval != 16'd0) begin
                        resp_status_in = 1'b0;
                        resp_owner_in  = entry.owner;
                     end
                  end
               end
               MODE_POST_FAIL: begin
                  if (entry.gen == gen_ff) begin
                     new_entry.pending = 1'b0;
                     wr_en          = 1'b1;
                     resp_status_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
            state_in = S_RSP;
         end
         S_RSP: begin
            if (out_free) begin
               load_out        = 1'b1;
               out_next.status = resp_status_ff;
               out_next.owner  = resp_owner_ff;
               state_in        = S_IDLE;
            end
         end
         S_SRD: begin
            rd_en    = 1'b1;
            state_in = S_SEX;
         end
         S_SEX: begin
            advance = 1'b1;
            unique case (mode_ff)
               MODE_CLR_OWNER: begin
                  if ((entry.interval != 16'd0) && (entry.owner == owner_ff)) begin
                     new_entry = kill_entry(entry);
                     wr_en     = 1'b1;
                  end
               end
               MODE_CANCEL: begin
                  new_entry = kill_entry(entry);
                  wr_en     = 1'b1;
               end
               MODE_TAKE_DUE: begin
                  if (eligible) begin
                     div_start = 1'b1;
                     cur_in    = entry;
                     advance   = 1'b0;
                     state_in  = S_DIV;
                  end
               end
               default: begin
               end
            endcase
            if (advance) begin
               if (last_idx) begin
                  if (mode_ff == MODE_TAKE_DUE) begin
                     state_in = S_FIN;
                  end else begin
                     resp_status_in = 1'b0;
                     state_in       = S_RSP;
                  end
               end else begin
                  idx_in   = idx_ff + SLOT_AW'(1);
                  state_in = S_SRD;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               new_entry         = cur_ff;
               new_entry.pending = 1'b1;
               new_entry.due     = new_due;
               wr_en             = 1'b1;
               state_in          = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!held_valid_ff || out_free) begin
               if (held_valid_ff) begin
                  load_out            = 1'b1;
                  out_next.tick_valid = 1'b1;
                  out_next.tick_slot  = held_slot_ff;
                  out_next.tick_gen   = held_gen_ff;
                  out_next.last       = 1'b0;
               end
               held_valid_in = 1'b1;
               held_slot_in  = idx_ext[2:0];
               held_gen_in   = cur_ff.gen;
               count_in      = count_ff + 4'd1;
               if (((count_ff + 4'd1) == limit_ff) || last_idx) begin
                  state_in = S_FIN;
               end else begin
                  idx_in   = idx_ff + SLOT_AW'(1);
                  state_in = S_SRD;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               load_out = 1'b1;
               if (held_valid_ff) begin
                  out_next.tick_valid = 1'b1;
                  out_next.tick_slot  = held_slot_ff;
                  out_next.tick_gen   = held_gen_ff;
               end else begin
                  out_next.status = 1'b1;
               end
               held_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      wr_data = EW'(new_entry);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         min_ivl_ff    <= MIN_IVL_RESET;
         max_ivl_ff    <= MAX_IVL_RESET;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
         limit_ff      <= '0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         if (take_req) begin
            limit_ff <= limit_in;
         end
         if (csr_valid) begin
            if (csr_index == CSR_MIN_IVL) begin
               min_ivl_ff <= csr_wdata;
            end else if (csr_index == CSR_MAX_IVL) begin
               max_ivl_ff <= csr_wdata;
            end
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[idx_ff];
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (take_req) begin
         mode_ff  <= req_mode;
         owner_ff <= req_owner_id;
         ivl_ff   <= req_interval_ms;
         now_ff   <= req_time_us;
         gen_ff   <= req_ticket_gen;
      end
      held_slot_ff   <= held_slot_in;
      held_gen_ff    <= held_gen_in;
      cur_ff         <= cur_in;
      resp_status_ff <= resp_status_in;
      resp_owner_ff  <= resp_owner_in;
      if (load_out) begin
         out_ff <= out_next;
      end
   end

   assign req_stall      = state_ff != S_IDLE;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_tick_valid = out_ff.tick_valid;
   assign rsp_tick_slot  = out_ff.tick_slot;
   assign rsp_tick_gen   = out_ff.tick_gen;
   assign rsp_owner_out  = out_ff.owner;
   assign rsp_last       = out_ff.last;

   `PTST_ASSERT_ALWAYS(a_ram_one_port, !(wr_en && rd_en), "slot RAM read and write overlap")
   `PTST_ASSERT(a_count_limit, count_ff <= limit_ff, "tick count passed the limit")
   `PTST_ASSERT(a_div_wait, div_start |=> (state_ff == S_DIV), "remainder started outside wait")
   `PTST_ASSERT(a_tick_ok, (rsp_valid && rsp_tick_valid) |-> !rsp_status, "tick with bad status")
endmodule
`default_nettype wire

// ===== rtl/ptst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/ptst_div.sv =====
// Bit-serial remainder unit: 64-bit dividend by period, one bit per cycle.
`default_nettype none
module ptst_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [63:0]               dividend,
   input  wire logic [ptst_pkg::PER_W-1:0] divisor,
   output logic                           done,
   output logic      [ptst_pkg::PER_W-1:0] remainder
);
   import ptst_pkg::*;

   logic [63:0]      shift_ff, shift_in;
   logic [PER_W-1:0] rem_ff, rem_in;
   logic [PER_W-1:0] dsr_ff, dsr_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [PER_W:0]   trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[63]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[62:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = PER_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[PER_W-1:0];
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire
